>>> rtl/oaee_pkg.sv
// Shared types and constants for the ordered array edit engine.
// No dependencies. The top level and the entry RAM import it.
package oaee_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  // A dump never returns more entries than this.
  localparam int DUMP_MAX  = 16;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_DUMP   = 2'd2,
    OP_DEDUP  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    op_t                       op;
    logic signed [DATA_W-1:0]  value;
    logic [4:0]                position;
  } in_req_t;

  typedef struct packed {
    status_t                   status;
    logic                      item_valid;
    logic signed [DATA_W-1:0]  entry_value;
    logic [3:0]                entry_index;
    logic                      last;
    logic [4:0]                count_after;
  } out_req_t;

endpackage

>>> rtl/oaee_ram.sv
// Entry store of the edit engine: one write port, one read port, registered read.
// Depends on oaee_pkg for the data width.
module oaee_ram import oaee_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/ordered_array_edit_engine.sv
// Ordered array edit engine: a list of signed entries held in a single-port-pair RAM.
// Insert shifts the entries above the position up before writing, delete shifts them down,
// dump reads and returns each entry, remove-duplicates compares each entry against the kept ones.
// One request is worked on at a time; the result register lets the next request in early.
// Reset (rst_n, synchronous) empties the list; RAM contents are not cleared, since only
// entries below the count are ever read.
module ordered_array_edit_engine import oaee_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_req_t out_data
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int XW = (CW > 5) ? CW : 5;
  localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);
  localparam logic [XW-1:0] DUMP_X  = XW'(DUMP_MAX);

  typedef enum logic [3:0] {
    S_IDLE, S_INS_SH, S_INS_WR, S_DEL_SH, S_DMP_RD, S_DMP_OUT,
    S_DD_NEXT, S_DD_CAND, S_DD_CMP, S_RESP
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [XW-1:0]            idx_r, idx_nxt;
  logic [CW-1:0]            kept_r, kept_nxt;
  logic [CW-1:0]            k_r, k_nxt;
  logic [4:0]               pos_r, pos_nxt;
  logic [DATA_W-1:0]        val_r, val_nxt;
  logic [DATA_W-1:0]        cand_r, cand_nxt;
  status_t                  status_r, status_nxt;
  logic                     pend_r, pend_nxt;
  logic [AW-1:0]            pend_addr_r, pend_addr_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_req_t                 out_data_r, out_data_nxt;

  logic                     ram_we, ram_re;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic [DATA_W-1:0]        ram_wdata, rd_data;

  logic                     out_free;
  logic [XW-1:0]            cnt_x, pos_x, in_pos_x, idx_m1, idx_p1, dump_n;
  logic [CW-1:0]            k_inc, kept_inc;

  oaee_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  assign out_free = !out_valid_r || out_ready;
  assign cnt_x    = XW'(count_r);
  assign pos_x    = XW'(pos_r);
  assign in_pos_x = XW'(in_data.position);
  assign idx_m1   = idx_r - 1'b1;
  assign idx_p1   = idx_r + 1'b1;
  assign dump_n   = (cnt_x > DUMP_X) ? DUMP_X : cnt_x;
  assign k_inc    = k_r + 1'b1;
  assign kept_inc = kept_r + 1'b1;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    kept_nxt      = kept_r;
    k_nxt         = k_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    cand_nxt      = cand_r;
    status_nxt    = status_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ram_re        = 1'b0;
    ram_raddr     = '0;
    // A shift step writes back the entry read in the previous cycle.
    ram_we        = pend_r;
    ram_waddr     = pend_addr_r;
    ram_wdata     = rd_data;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          pos_nxt    = in_data.position;
          val_nxt    = in_data.value;
          status_nxt = ST_OK;
          unique case (in_data.op)
            OP_INSERT: begin
              if (in_pos_x > cnt_x) begin
                status_nxt = ST_BAD_POS;
                state_nxt  = S_RESP;
              end else if (cnt_x == DEPTH_X) begin
                status_nxt = ST_FULL;
                state_nxt  = S_RESP;
              end else begin
                idx_nxt   = cnt_x;
                state_nxt = S_INS_SH;
              end
            end
            OP_DELETE: begin
              if (in_pos_x >= cnt_x) begin
                status_nxt = ST_BAD_POS;
                state_nxt  = S_RESP;
              end else begin
                idx_nxt   = in_pos_x + 1'b1;
                state_nxt = S_DEL_SH;
              end
            end
            OP_DUMP: begin
              idx_nxt   = '0;
              state_nxt = (count_r == '0) ? S_RESP : S_DMP_RD;
            end
            OP_DEDUP: begin
              idx_nxt   = '0;
              kept_nxt  = '0;
              state_nxt = S_DD_NEXT;
            end
          endcase
        end
      end

      // Entries move up one place, highest first, with read and write overlapped.
      S_INS_SH: begin
        if (idx_r > pos_x) begin
          ram_re        = 1'b1;
          ram_raddr     = idx_m1[AW-1:0];
          pend_nxt      = 1'b1;
          pend_addr_nxt = idx_r[AW-1:0];
          idx_nxt       = idx_m1;
        end else begin
          state_nxt = S_INS_WR;
        end
      end

      S_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = pos_x[AW-1:0];
        ram_wdata = val_r;
        count_nxt = count_r + 1'b1;
        state_nxt = S_RESP;
      end

      S_DEL_SH: begin
        if (idx_r < cnt_x) begin
          ram_re        = 1'b1;
          ram_raddr     = idx_r[AW-1:0];
          pend_nxt      = 1'b1;
          pend_addr_nxt = idx_m1[AW-1:0];
          idx_nxt       = idx_p1;
        end else begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_RESP;
        end
      end

      S_DMP_RD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_r[AW-1:0];
        state_nxt = S_DMP_OUT;
      end

      S_DMP_OUT: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = ST_OK;
          out_data_nxt.item_valid  = 1'b1;
          out_data_nxt.entry_value = rd_data;
          out_data_nxt.entry_index = idx_r[3:0];
          out_data_nxt.last        = (idx_p1 == dump_n);
          out_data_nxt.count_after = cnt_x[4:0];
          if (idx_p1 == dump_n) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_p1;
            state_nxt = S_DMP_RD;
          end
        end
      end

      // Outer pass over the list: fetch the next candidate or finish.
      S_DD_NEXT: begin
        if (idx_r == cnt_x) begin
          count_nxt = kept_r;
          state_nxt = S_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_r[AW-1:0];
          state_nxt = S_DD_CAND;
        end
      end

      S_DD_CAND: begin
        cand_nxt = rd_data;
        if (kept_r == '0) begin
          ram_we    = 1'b1;
          ram_waddr = kept_r[AW-1:0];
          ram_wdata = rd_data;
          kept_nxt  = kept_inc;
          idx_nxt   = idx_p1;
          state_nxt = S_DD_NEXT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = '0;
          k_nxt     = '0;
          state_nxt = S_DD_CMP;
        end
      end

      // Compare the candidate against each kept entry, reading the next one meanwhile.
      S_DD_CMP: begin
        if (rd_data == cand_r) begin
          idx_nxt   = idx_p1;
          state_nxt = S_DD_NEXT;
        end else if (k_inc == kept_r) begin
          ram_we    = 1'b1;
          ram_waddr = kept_r[AW-1:0];
          ram_wdata = cand_r;
          kept_nxt  = kept_inc;
          idx_nxt   = idx_p1;
          state_nxt = S_DD_NEXT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = k_inc[AW-1:0];
          k_nxt     = k_inc;
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = status_r;
          out_data_nxt.item_valid  = 1'b0;
          out_data_nxt.entry_value = '0;
          out_data_nxt.entry_index = '0;
          out_data_nxt.last        = 1'b1;
          out_data_nxt.count_after = cnt_x[4:0];
          state_nxt                = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      kept_r      <= '0;
      k_r         <= '0;
      status_r    <= ST_OK;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      kept_r      <= kept_nxt;
      k_r         <= k_nxt;
      status_r    <= status_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r       <= pos_nxt;
    val_r       <= val_nxt;
    cand_r      <= cand_nxt;
    pend_addr_r <= pend_addr_nxt;
    out_data_r  <= out_data_nxt;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_x <= DEPTH_X)
    else $error("entry count above depth");

  a_wr_addr: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (XW'(ram_waddr) < DEPTH_X))
    else $error("RAM write beyond depth");

  a_no_wr_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS_WR || state_r == S_DD_CAND || state_r == S_DD_CMP) |-> !pend_r)
    else $error("shift write-back overlaps another write");

  a_dedup_k: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DD_CMP) |-> (k_r < kept_r && XW'(kept_r) <= idx_r))
    else $error("duplicate scan index out of order");

  a_dump_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DMP_RD) |-> (idx_r < cnt_x && idx_r < DUMP_X))
    else $error("dump reads past the list");
`endif

endmodule

>>> verif/tb_ordered_array_edit_engine.sv
`timescale 1ns / 100ps
// Self-checking testbench for ordered_array_edit_engine: a queue-fed request driver,
// an output monitor and a list predictor for insert, delete, dump and de-duplication.
// Depends on oaee_pkg and the RTL top level only.
module tb_ordered_array_edit_engine;
  import oaee_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 300;
  localparam int RAND_ITEMS   = 150;
  localparam int MAX_REPORTS  = 20;

  typedef struct {
    logic signed [DATA_W-1:0] mem [DEPTH_DEF];
    int unsigned              len;
  } edit_list_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  in_req_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_req_t out_data;

  in_req_t    pending_q[$];
  out_req_t   expected_q[$];
  edit_list_t live_list;
  edit_list_t plan_list;
  logic signed [DATA_W-1:0] value_pool [8];

  int gap_left       = 0;
  int stall_left     = 0;
  int sent_cnt       = 0;
  int checked_cnt    = 0;
  int err_cnt        = 0;
  int full_cnt       = 0;
  int bad_pos_cnt    = 0;
  int dump_entry_cnt = 0;
  int cycle_cnt      = 0;

  ordered_array_edit_engine u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one request to a list and returns the results it gives.
  task automatic edit_list(inout edit_list_t lst, input in_req_t req,
                           output out_req_t res_q[$]);
    out_req_t    res;
    int unsigned n;
    int unsigned kept;
    bit          seen;
    res_q = {};
    res = '0;
    res.status = ST_OK;
    res.last = 1'b1;
    case (req.op)
      OP_INSERT: begin
        if (req.position > lst.len) begin
          res.status = ST_BAD_POS;
        end else if (lst.len >= DEPTH_DEF) begin
          res.status = ST_FULL;
        end else begin
          for (int i = lst.len; i > req.position; i--) lst.mem[i] = lst.mem[i-1];
          lst.mem[req.position] = req.value;
          lst.len++;
        end
      end
      OP_DELETE: begin
        if (req.position >= lst.len) begin
          res.status = ST_BAD_POS;
        end else begin
          for (int i = req.position; i + 1 < lst.len; i++) lst.mem[i] = lst.mem[i+1];
          lst.len--;
        end
      end
      OP_DEDUP: begin
        kept = 0;
        for (int i = 0; i < lst.len; i++) begin
          seen = 1'b0;
          for (int k = 0; k < kept; k++) if (lst.mem[k] === lst.mem[i]) seen = 1'b1;
          if (!seen) begin
            lst.mem[kept] = lst.mem[i];
            kept++;
          end
        end
        lst.len = kept;
      end
      OP_DUMP: begin
        n = (lst.len > DUMP_MAX) ? DUMP_MAX : lst.len;
        for (int i = 0; i < n; i++) begin
          res.item_valid = 1'b1;
          res.entry_value = lst.mem[i];
          res.entry_index = 4'(i);
          res.last = (i + 1 == n);
          res.count_after = 5'(lst.len);
          res_q.push_back(res);
        end
      end
    endcase
    // Everything but a non-empty dump gives a single closing result.
    if (res_q.size() == 0) begin
      res.count_after = 5'(lst.len);
      res_q.push_back(res);
    end
  endtask

  // Queues a request and advances the planning copy, so that later requests
  // can be aimed at the count the list will have by then.
  task automatic add_item(input op_t op, input logic signed [DATA_W-1:0] value,
                          input int pos);
    in_req_t  req;
    out_req_t scratch[$];
    req.op = op;
    req.value = value;
    req.position = 5'(pos);
    pending_q.push_back(req);
    edit_list(plan_list, req, scratch);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    // Pool values make duplicates common enough for de-duplication to bite.
    if (r < 45) return value_pool[$urandom_range(0, 7)];
    if (r < 55) return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
    return $urandom;
  endfunction

  function automatic int pick_gap(input bit idle_on);
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic string show(input out_req_t r);
    return $sformatf("status=%0d valid=%0b value=%0d index=%0d last=%0b count=%0d",
                     r.status, r.item_valid, r.entry_value, r.entry_index, r.last,
                     r.count_after);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_q.size() > 0) begin
        in_data <= pending_q.pop_front();
        in_valid <= 1'b1;
        // Every fourth stretch of fifty requests runs back to back.
        gap_left <= pick_gap(((sent_cnt / 50) % 4) != 2);
        sent_cnt <= sent_cnt + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      stall_left <= pick_gap(((checked_cnt / 40) % 4) != 1);
    end
  end

  always @(posedge clk) begin : monitor
    out_req_t got;
    out_req_t want;
    out_req_t fresh[$];
    if (rst_n) begin
      if (in_valid && in_ready) begin
        edit_list(live_list, in_data, fresh);
        foreach (fresh[k]) begin
          expected_q.push_back(fresh[k]);
          if (fresh[k].status == ST_FULL) full_cnt++;
          if (fresh[k].status == ST_BAD_POS) bad_pos_cnt++;
          if (fresh[k].item_valid) dump_entry_cnt++;
        end
      end
      if (out_valid && out_ready) begin
        got = out_data;
        checked_cnt <= checked_cnt + 1;
        if (expected_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("%0t: unexpected result, expected none, got %s", $time, show(got));
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS) begin
              $display("%0t: result mismatch", $time);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(got));
            end
          end
        end
      end
    end
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) @(negedge clk);
    $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
             expected_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int unsigned len;
    int          r;
    value_pool = '{32'sd0, -32'sd1, 32'sd1, 32'sd42, 32'sh7fffffff, 32'sh80000000,
                   32'sh55555555, -32'sd1000};
    plan_list.len = 0;
    live_list.len = 0;

    // Empty list: dump, delete and an insert past the end.
    add_item(OP_DUMP, 32'sd0, 0);
    add_item(OP_DELETE, 32'sd0, 0);
    add_item(OP_INSERT, 32'sd5, 1);
    // Inserts at the front, the end and the middle, with the value extremes.
    add_item(OP_INSERT, 32'sh7fffffff, 0);
    add_item(OP_INSERT, 32'sh80000000, 0);
    add_item(OP_INSERT, 32'sd0, 2);
    add_item(OP_INSERT, -32'sd1, 1);
    add_item(OP_INSERT, 32'sh7fffffff, 4);
    add_item(OP_DUMP, 32'sd0, 0);
    add_item(OP_DEDUP, 32'sd0, 0);
    add_item(OP_DUMP, 32'sd0, 0);
    // Deletes out of range, then the last entry.
    add_item(OP_DELETE, 32'sd0, 16);
    add_item(OP_DELETE, 32'sd0, plan_list.len);
    add_item(OP_DELETE, 32'sd0, plan_list.len - 1);
    // Fill the list, then insert into the full list at both ends.
    while (plan_list.len < DEPTH_DEF)
      add_item(OP_INSERT, value_pool[plan_list.len % 8], $urandom_range(0, plan_list.len));
    add_item(OP_INSERT, 32'sd9, 16);
    add_item(OP_INSERT, 32'sd9, 0);
    add_item(OP_DUMP, 32'sd0, 0);
    add_item(OP_DEDUP, 32'sd0, 0);
    add_item(OP_DUMP, 32'sd0, 0);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      len = plan_list.len;
      if (r < 45) begin
        // A valid position; once the list is full this is refused.
        add_item(OP_INSERT, pick_value(), $urandom_range(0, len));
      end else if (r < 65) begin
        if (len == 0) add_item(OP_DELETE, pick_value(), $urandom_range(0, 16));
        else add_item(OP_DELETE, pick_value(), $urandom_range(0, len - 1));
      end else if (r < 80) begin
        add_item(OP_DUMP, pick_value(), $urandom_range(0, 16));
      end else if (r < 90) begin
        add_item(OP_DEDUP, pick_value(), $urandom_range(0, 16));
      end else if (len < DEPTH_DEF && $urandom_range(0, 1) != 0) begin
        add_item(OP_INSERT, pick_value(), $urandom_range(len + 1, 16));
      end else begin
        add_item(OP_DELETE, pick_value(), $urandom_range(len, 16));
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d requests and %0d results, %0d of them dumped entries;",
             sent_cnt, checked_cnt, dump_entry_cnt);
    $display("%0d requests hit a bad position, %0d inserts met a full list, %0d errors.",
             bad_pos_cnt, full_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/oaee_pkg.sv
rtl/oaee_ram.sv
rtl/ordered_array_edit_engine.sv
verif/tb_ordered_array_edit_engine.sv
